FILE: rtl/core/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Types and codes shared by the signature section parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  // register indexes on the configuration port
  localparam logic [0:0] REG_SECTION_SIZE = 1'd0;
  localparam logic [0:0] REG_TAG_LIMIT    = 1'd1;

  localparam logic [7:0] TAG_LIMIT_RESET = 8'd16;

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_HEAD  = 3'd1,
    PH_PTAG  = 3'd2,
    PH_PPAD  = 3'd3,
    PH_RTAG  = 3'd4,
    PH_RPAD  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PTAG   = 3'd0,
    KIND_RTAG   = 3'd1,
    KIND_ENTRY  = 3'd2,
    KIND_ACCEPT = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_TAG   = 2'd2,
    ERR_PAD   = 2'd3
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] entry_index;
    logic [15:0] n_params;
    logic [15:0] n_results;
    logic [7:0]  tag_value;
    logic [15:0] tag_position;
    err_t        error_code;
    logic        last_of_run;
  } res_t;

  // results caused by one byte, up to three
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      item;
  } batch_t;

endpackage

`default_nettype wire

FILE: rtl/core/ssp_parse.sv
// ----------------------------------------------------------------------------
// ssp_parse
// Parser state and the per-byte step logic; emits up to three result words.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic [7:0]     data_byte,
  input  wire logic           eos,
  input  wire logic [31:0]    section_size,
  input  wire logic [7:0]     tag_limit,
  output ssp_pkg::batch_t     batch
);
  import ssp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  bif_r, bif_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] num_r, num_nxt;
  logic [15:0] pn_r, pn_nxt;
  logic [15:0] rn_r, rn_nxt;
  logic [15:0] lp_r, lp_nxt;
  logic        fin_r, fin_nxt;

  logic [31:0] limit;
  logic [1:0]  k;
  logic        start_res;
  logic        ent_done;
  logic        is_res;
  logic [15:0] list_total;

  function automatic res_t mk(kind_t kd, logic [31:0] en, logic [15:0] pc,
                              logic [15:0] rc, logic [7:0] tg, logic [15:0] ps,
                              err_t ec);
    res_t r;
    r.kind         = kd;
    r.entry_index  = en;
    r.n_params     = pc;
    r.n_results    = rc;
    r.tag_value    = tg;
    r.tag_position = ps;
    r.error_code   = ec;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  assign limit = (section_size >= 32'd4) ? (section_size >> 2) - 32'd1 : 32'd0;

  always_comb begin
    phase_nxt = phase_r;
    bif_nxt   = bif_r;
    total_nxt = total_r;
    num_nxt   = num_r;
    pn_nxt    = pn_r;
    rn_nxt    = rn_r;
    lp_nxt    = lp_r;
    fin_nxt   = fin_r;
    batch     = '0;
    k         = 2'd0;
    start_res = 1'b0;
    ent_done  = 1'b0;
    is_res    = (phase_r == PH_RTAG) || (phase_r == PH_RPAD);
    list_total = is_res ? rn_r : pn_r;

    if (!fin_r) begin
      unique case (phase_r)
        PH_COUNT: begin
          unique case (bif_r)
            2'd0: total_nxt[7:0]   = data_byte;
            2'd1: total_nxt[15:8]  = data_byte;
            2'd2: total_nxt[23:16] = data_byte;
            default: total_nxt[31:24] = data_byte;
          endcase
          if (bif_r != 2'd3) begin
            bif_nxt = bif_r + 2'd1;
          end else if (total_nxt == 32'd0) begin
            fin_nxt = 1'b1;
            batch.item[k] = mk(KIND_ACCEPT, num_nxt, pn_nxt, rn_nxt, 8'd0, 16'd0,
                               ERR_NONE);
            k = k + 2'd1;
          end else if (total_nxt > limit) begin
            fin_nxt = 1'b1;
            batch.item[k] = mk(KIND_ERROR, num_nxt, pn_nxt, rn_nxt, 8'd0, 16'd0,
                               ERR_TRUNC);
            k = k + 2'd1;
          end else begin
            phase_nxt = PH_HEAD;
            bif_nxt   = 2'd0;
            pn_nxt    = 16'd0;
            rn_nxt    = 16'd0;
            lp_nxt    = 16'd0;
          end
        end
        PH_HEAD: begin
          unique case (bif_r)
            2'd0: pn_nxt = {8'd0, data_byte};
            2'd1: pn_nxt = {data_byte, pn_r[7:0]};
            2'd2: rn_nxt = {8'd0, data_byte};
            default: rn_nxt = {data_byte, rn_r[7:0]};
          endcase
          if (bif_r != 2'd3) begin
            bif_nxt = bif_r + 2'd1;
          end else begin
            lp_nxt  = 16'd0;
            bif_nxt = 2'd0;
            if (pn_nxt == 16'd0) begin
              start_res = 1'b1;
            end else begin
              phase_nxt = PH_PTAG;
            end
          end
        end
        PH_PTAG, PH_RTAG: begin
          if (data_byte >= tag_limit) begin
            fin_nxt = 1'b1;
            batch.item[k] = mk(KIND_ERROR, num_nxt, pn_nxt, rn_nxt, data_byte, lp_r,
                               ERR_TAG);
            k = k + 2'd1;
          end else begin
            batch.item[k] = mk(is_res ? KIND_RTAG : KIND_PTAG, num_nxt, pn_nxt,
                               rn_nxt, data_byte, lp_r, ERR_NONE);
            k = k + 2'd1;
            lp_nxt  = lp_r + 16'd1;
            bif_nxt = bif_r + 2'd1;
            if (lp_nxt == list_total) begin
              if (bif_nxt == 2'd0) begin
                if (is_res) ent_done = 1'b1;
                else start_res = 1'b1;
              end else begin
                phase_nxt = is_res ? PH_RPAD : PH_PPAD;
              end
            end
          end
        end
        PH_PPAD, PH_RPAD: begin
          if (data_byte != 8'd0) begin
            fin_nxt = 1'b1;
            batch.item[k] = mk(KIND_ERROR, num_nxt, pn_nxt, rn_nxt, 8'd0, 16'd0,
                               ERR_PAD);
            k = k + 2'd1;
          end else begin
            bif_nxt = bif_r + 2'd1;
            if (bif_nxt == 2'd0) begin
              if (is_res) ent_done = 1'b1;
              else start_res = 1'b1;
            end
          end
        end
        default: fin_nxt = 1'b1;
      endcase
    end

    // parameter list done: move on to the result list
    if (start_res) begin
      lp_nxt  = 16'd0;
      bif_nxt = 2'd0;
      if (rn_nxt == 16'd0) ent_done = 1'b1;
      else phase_nxt = PH_RTAG;
    end

    if (ent_done) begin
      batch.item[k] = mk(KIND_ENTRY, num_nxt, pn_nxt, rn_nxt, 8'd0, 16'd0, ERR_NONE);
      k = k + 2'd1;
      num_nxt = num_nxt + 32'd1;
      if (num_nxt == total_nxt) begin
        batch.item[k] = mk(KIND_ACCEPT, num_nxt, pn_nxt, rn_nxt, 8'd0, 16'd0,
                           ERR_NONE);
        k = k + 2'd1;
        fin_nxt = 1'b1;
      end else begin
        phase_nxt = PH_HEAD;
        bif_nxt   = 2'd0;
        pn_nxt    = 16'd0;
        rn_nxt    = 16'd0;
        lp_nxt    = 16'd0;
      end
    end

    // end of section: flag an unfinished parse, then rearm
    if (eos) begin
      if (!fin_nxt) begin
        batch.item[k] = mk(KIND_ERROR, num_nxt, pn_nxt, rn_nxt, 8'd0, 16'd0,
                           ERR_TRUNC);
        k = k + 2'd1;
      end
      phase_nxt = PH_COUNT;
      bif_nxt   = 2'd0;
      total_nxt = 32'd0;
      num_nxt   = 32'd0;
      pn_nxt    = 16'd0;
      rn_nxt    = 16'd0;
      lp_nxt    = 16'd0;
      fin_nxt   = 1'b0;
    end

    if (k != 2'd0) batch.item[k - 2'd1].last_of_run = 1'b1;
    batch.cnt = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      bif_r   <= 2'd0;
      total_r <= 32'd0;
      num_r   <= 32'd0;
      pn_r    <= 16'd0;
      rn_r    <= 16'd0;
      lp_r    <= 16'd0;
      fin_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bif_r   <= bif_nxt;
      total_r <= total_nxt;
      num_r   <= num_nxt;
      pn_r    <= pn_nxt;
      rn_r    <= rn_nxt;
      lp_r    <= lp_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssp_outq.sv
// ----------------------------------------------------------------------------
// ssp_outq
// Four-word result queue: up to three words in a cycle, one out unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ssp_pkg::batch_t batch,
  input  wire logic           out_stall,
  output logic                out_valid,
  output ssp_pkg::res_t       head,
  output logic                room
);
  import ssp_pkg::*;

  res_t [3:0]  slot_r, slot_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  push_n;
  logic        pop;
  logic [2:0]  base;
  logic [2:0]  ofs;

  assign out_valid = (cnt_r != 3'd0);
  assign head      = slot_r[0];
  assign room      = (cnt_r <= 3'd1);
  assign pop       = out_valid && !out_stall;
  assign push_n    = push ? batch.cnt : 2'd0;
  assign base      = cnt_r - {2'd0, pop};

  always_comb begin
    cnt_nxt = base + {1'b0, push_n};
    for (int i = 0; i < 4; i++) begin
      ofs = 3'(i) - base;
      slot_nxt[i] = slot_r[i];
      if (3'(i) < base) begin
        // shift down one place on a pop
        if (pop && i < 3) slot_nxt[i] = slot_r[2'(i + 1)];
      end else if (ofs < {1'b0, push_n}) begin
        slot_nxt[i] = batch.item[ofs[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> (cnt_r <= 3'd1))
    else $error("result words pushed without room");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue overflow");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_n == 2'd0) |=> (cnt_r == $past(cnt_r) - 3'd1))
    else $error("queue count lost track on pop");

  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> batch.item[push_n - 2'd1].last_of_run)
    else $error("last word of a byte not marked");

endmodule

`default_nettype wire

FILE: rtl/core/signature_section_parser.sv
// ----------------------------------------------------------------------------
// signature_section_parser
// Byte-wise checker for a signature section: entry count, headers, tags, pads.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_wdata
//   in       in         in_valid / in_stall  in_data_byte, in_end_of_section
//   out      out        out_valid/out_stall  kind, entry_index, counts, tag, error
//
// One byte is accepted per cycle while in_stall is low. A byte causes up to
// three words; the result queue hands out one per cycle while out_stall is low,
// and a waiting byte stalls the input while the queue holds more than one word.
// Reset is synchronous and active low; no clearing pass is needed.
// The user must write configuration only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
`default_nettype none

module signature_section_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_section,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_entry_index,
  output logic [15:0]      out_n_params,
  output logic [15:0]      out_n_results,
  output logic [7:0]       out_tag_value,
  output logic [15:0]      out_tag_position,
  output logic [1:0]       out_error_code,
  output logic             out_last_of_run
);
  import ssp_pkg::*;

  logic [31:0] section_size_r;
  logic [7:0]  tag_limit_r;
  logic        in_v_r;
  logic [7:0]  byte_r;
  logic        eos_r;
  logic        room;
  logic        advance;
  batch_t      batch;
  res_t        head;

  assign advance  = in_v_r && room;
  assign in_stall = in_v_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_size_r <= 32'd0;
      tag_limit_r    <= TAG_LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SECTION_SIZE) section_size_r <= cfg_wdata;
      else if (cfg_index == REG_TAG_LIMIT) tag_limit_r <= cfg_wdata[7:0];
    end
  end

  // input word register: load on accept, drop once the step has run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_data_byte;
      eos_r  <= in_end_of_section;
    end
  end

  ssp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .data_byte    (byte_r),
    .eos          (eos_r),
    .section_size (section_size_r),
    .tag_limit    (tag_limit_r),
    .batch        (batch)
  );

  ssp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .batch     (batch),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .room      (room)
  );

  assign out_kind         = head.kind;
  assign out_entry_index  = head.entry_index;
  assign out_n_params     = head.n_params;
  assign out_n_results    = head.n_results;
  assign out_tag_value    = head.tag_value;
  assign out_tag_position = head.tag_position;
  assign out_error_code   = head.error_code;
  assign out_last_of_run  = head.last_of_run;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for signature_section_parser. Section bytes are queued
// by a stimulus process, sent by a clocked driver under random idling, and
// predicted at acceptance; a clocked monitor compares every result word with
// the oldest predicted word, field by field. Register settings change
// between phases while the parser is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ssp_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } sec_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_SECTION_SIZE;
  logic [31:0] cfg_wdata = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_section = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_entry_index;
  logic [15:0] out_n_params;
  logic [15:0] out_n_results;
  logic [7:0]  out_tag_value;
  logic [15:0] out_tag_position;
  logic [1:0]  out_error_code;
  logic        out_last_of_run;

  signature_section_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_section (in_end_of_section),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_entry_index   (out_entry_index),
    .out_n_params      (out_n_params),
    .out_n_results     (out_n_results),
    .out_tag_value     (out_tag_value),
    .out_tag_position  (out_tag_position),
    .out_error_code    (out_error_code),
    .out_last_of_run   (out_last_of_run)
  );

  always #5 clk = ~clk;

  // pending section bytes, section under construction, predicted words
  sec_byte_t   byte_q[$];
  logic [7:0]  sec_buf[$];
  res_t        exp_words[$];
  res_t        run_words[$];

  int unsigned pushed_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned bad_cnt = 0;
  int unsigned section_cnt = 0;
  int unsigned setting_cnt = 0;
  bit          calm = 1'b0;

  // parser shadow: registers and stream state
  logic [31:0] sec_size = 32'd0;
  logic [7:0]  tag_lim = TAG_LIMIT_RESET;
  phase_t      prs_phase = PH_COUNT;
  logic [1:0]  prs_bif = 2'd0;
  logic [31:0] prs_total = 32'd0;
  logic [31:0] prs_entry = 32'd0;
  logic [15:0] prs_params = 16'd0;
  logic [15:0] prs_results = 16'd0;
  logic [15:0] prs_pos = 16'd0;
  bit          prs_done = 1'b0;

  task automatic note_word(kind_t k, logic [7:0] tag, logic [15:0] pos, err_t e);
    res_t r;
    r.kind         = k;
    r.entry_index  = prs_entry;
    r.n_params     = prs_params;
    r.n_results    = prs_results;
    r.tag_value    = tag;
    r.tag_position = pos;
    r.error_code   = e;
    r.last_of_run  = 1'b0;
    run_words.push_back(r);
  endtask

  task automatic open_header();
    prs_phase   = PH_HEAD;
    prs_bif     = 2'd0;
    prs_params  = 16'd0;
    prs_results = 16'd0;
    prs_pos     = 16'd0;
  endtask

  task automatic close_entry();
    note_word(KIND_ENTRY, 8'd0, 16'd0, ERR_NONE);
    prs_entry++;
    if (prs_entry == prs_total) begin
      note_word(KIND_ACCEPT, 8'd0, 16'd0, ERR_NONE);
      prs_done = 1'b1;
    end else begin
      open_header();
    end
  endtask

  task automatic open_results();
    prs_pos = 16'd0;
    prs_bif = 2'd0;
    if (prs_results == 16'd0) close_entry();
    else prs_phase = PH_RTAG;
  endtask

  task automatic take_tag(logic [7:0] b, bit is_res);
    logic [15:0] total;
    total = is_res ? prs_results : prs_params;
    if (b >= tag_lim) begin
      prs_done = 1'b1;
      note_word(KIND_ERROR, b, prs_pos, ERR_TAG);
      return;
    end
    note_word(is_res ? KIND_RTAG : KIND_PTAG, b, prs_pos, ERR_NONE);
    prs_pos++;
    prs_bif++;
    if (prs_pos == total) begin
      if (prs_bif == 2'd0) begin
        if (is_res) close_entry();
        else open_results();
      end else begin
        prs_phase = is_res ? PH_RPAD : PH_PPAD;
      end
    end
  endtask

  task automatic take_pad(logic [7:0] b, bit is_res);
    if (b != 8'd0) begin
      prs_done = 1'b1;
      note_word(KIND_ERROR, 8'd0, 16'd0, ERR_PAD);
      return;
    end
    prs_bif++;
    if (prs_bif == 2'd0) begin
      if (is_res) close_entry();
      else open_results();
    end
  endtask

  task automatic parse_sig_byte(logic [7:0] b);
    logic [31:0] lim;
    case (prs_phase)
      PH_COUNT: begin
        prs_total = prs_total | ({24'd0, b} << (8 * prs_bif));
        if (prs_bif != 2'd3) begin
          prs_bif++;
        end else if (prs_total == 32'd0) begin
          // empty section: accept without the size check
          prs_done = 1'b1;
          note_word(KIND_ACCEPT, 8'd0, 16'd0, ERR_NONE);
        end else begin
          lim = (sec_size >= 32'd4) ? (sec_size - 32'd4) / 32'd4 : 32'd0;
          if (prs_total > lim) begin
            prs_done = 1'b1;
            note_word(KIND_ERROR, 8'd0, 16'd0, ERR_TRUNC);
          end else begin
            open_header();
          end
        end
      end
      PH_HEAD: begin
        case (prs_bif)
          2'd0: prs_params = {8'd0, b};
          2'd1: prs_params[15:8] = b;
          2'd2: prs_results = {8'd0, b};
          default: prs_results[15:8] = b;
        endcase
        if (prs_bif != 2'd3) begin
          prs_bif++;
        end else begin
          prs_pos = 16'd0;
          prs_bif = 2'd0;
          if (prs_params == 16'd0) open_results();
          else prs_phase = PH_PTAG;
        end
      end
      PH_PTAG: take_tag(b, 1'b0);
      PH_PPAD: take_pad(b, 1'b0);
      PH_RTAG: take_tag(b, 1'b1);
      PH_RPAD: take_pad(b, 1'b1);
      default: prs_done = 1'b1;
    endcase
  endtask

  task automatic predict_byte(logic [7:0] b, logic eos);
    res_t r;
    run_words.delete();
    if (!prs_done) parse_sig_byte(b);
    if (eos) begin
      // unfinished parse at end of section is truncated
      if (!prs_done) note_word(KIND_ERROR, 8'd0, 16'd0, ERR_TRUNC);
      prs_phase   = PH_COUNT;
      prs_bif     = 2'd0;
      prs_total   = 32'd0;
      prs_entry   = 32'd0;
      prs_params  = 16'd0;
      prs_results = 16'd0;
      prs_pos     = 16'd0;
      prs_done    = 1'b0;
    end
    if (run_words.size() != 0) begin
      r = run_words.pop_back();
      r.last_of_run = 1'b1;
      run_words.push_back(r);
    end
    foreach (run_words[i]) exp_words.push_back(run_words[i]);
  endtask

  // driver: hold the word while stalled, advance on acceptance
  always @(posedge clk) begin : drive
    sec_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(in_data_byte, in_end_of_section);
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
          nxt = byte_q.pop_front();
          in_valid          <= 1'b1;
          in_data_byte      <= nxt.b;
          in_end_of_section <= nxt.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind         = kind_t'(out_kind);
        got.entry_index  = out_entry_index;
        got.n_params     = out_n_params;
        got.n_results    = out_n_results;
        got.tag_value    = out_tag_value;
        got.tag_position = out_tag_position;
        got.error_code   = err_t'(out_error_code);
        got.last_of_run  = out_last_of_run;
        if (exp_words.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("unexpected word: kind=%0d entry=%0d err=%0d", got.kind,
                     got.entry_index, got.error_code);
        end else begin
          want = exp_words.pop_front();
          checked_cnt++;
          if (got.kind !== want.kind || got.entry_index !== want.entry_index ||
              got.n_params !== want.n_params ||
              got.n_results !== want.n_results ||
              got.tag_value !== want.tag_value ||
              got.tag_position !== want.tag_position ||
              got.error_code !== want.error_code ||
              got.last_of_run !== want.last_of_run) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("mismatch exp: kind=%0d entry=%0d pc=%0d rc=%0d tag=%0d pos=%0d err=%0d last=%0d",
                       want.kind, want.entry_index, want.n_params, want.n_results,
                       want.tag_value, want.tag_position, want.error_code, want.last_of_run);
              $display("         got: kind=%0d entry=%0d pc=%0d rc=%0d tag=%0d pos=%0d err=%0d last=%0d",
                       got.kind, got.entry_index, got.n_params, got.n_results,
                       got.tag_value, got.tag_position, got.error_code, got.last_of_run);
            end
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 26);
    end
  end

  task automatic put_b(logic [7:0] b);
    sec_buf.push_back(b);
  endtask

  task automatic put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) put_b(w[8*i +: 8]);
  endtask

  // move the built section to the driver queue, end flag on its last byte
  task automatic flush_section();
    sec_byte_t it;
    foreach (sec_buf[i]) begin
      it.b   = sec_buf[i];
      it.eos = (i == sec_buf.size() - 1);
      byte_q.push_back(it);
      pushed_cnt++;
    end
    sec_buf.delete();
    section_cnt++;
  endtask

  function automatic logic [7:0] pick_tag();
    if (tag_lim == 8'd0 || $urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(0, tag_lim - 8'd1));
  endfunction

  task automatic add_section();
    logic [31:0] lim;
    logic [31:0] n;
    logic [31:0] pc;
    logic [31:0] rc;
    int unsigned mode;
    int unsigned cut;
    bit          big;
    lim  = (sec_size >= 32'd4) ? (sec_size - 32'd4) / 32'd4 : 32'd0;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 8)) put_b(8'($urandom));
    end else begin
      if ($urandom_range(0, 9) == 0) n = lim + 32'd1;
      else n = $urandom_range(0, (lim < 32'd3) ? lim : 32'd3);
      put_word(n);
      if (n > lim) begin
        put_b(8'($urandom));
      end else begin
        for (int e = 0; e < n; e++) begin
          big = ($urandom_range(0, 19) == 0);
          pc = big ? $urandom_range(0, 65535) : $urandom_range(0, $urandom_range(0, 1) ? 6 : 13);
          rc = big ? $urandom_range(0, 65535) : $urandom_range(0, $urandom_range(0, 1) ? 6 : 13);
          put_b(pc[7:0]);
          put_b(pc[15:8]);
          put_b(rc[7:0]);
          put_b(rc[15:8]);
          if (big) begin
            // huge counts: a few tags, then the section ends early
            repeat ($urandom_range(0, 5)) put_b(pick_tag());
            break;
          end
          repeat (pc) put_b(pick_tag());
          repeat ((4 - pc % 4) % 4) put_b(8'd0);
          repeat (rc) put_b(pick_tag());
          repeat ((4 - rc % 4) % 4) put_b(8'd0);
        end
      end
      if (mode < 20) begin
        sec_buf[$urandom_range(0, sec_buf.size() - 1)] = 8'($urandom);
      end else if (mode < 30) begin
        cut = $urandom_range(1, sec_buf.size());
        while (sec_buf.size() > cut) void'(sec_buf.pop_back());
      end else if (mode < 38) begin
        repeat ($urandom_range(1, 4)) put_b(8'($urandom));
      end
    end
    flush_section();
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SECTION_SIZE) sec_size = val;
    else tag_lim = val[7:0];
  endtask

  // wait until every byte is taken and every word has come back
  task automatic drain();
    while (sent_cnt != pushed_cnt || exp_words.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] sz;
    logic [7:0]  tl;
    int unsigned mark;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_SECTION_SIZE, 32'd64);
    setting_cnt++;
    // empty section
    put_word(32'd0);
    flush_section();
    // count far too large, then trailing bytes ignored
    put_word(32'hFFFF_FFFF);
    put_b(8'h55);
    put_b(8'hAA);
    flush_section();
    // one parameter tag at the top of the range, then a bad pad byte
    put_word(32'd1);
    put_word(32'h0000_0001);
    put_b(8'h0F);
    put_b(8'h80);
    flush_section();
    // section ends inside a header
    put_word(32'd2);
    put_b(8'h01);
    flush_section();
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin sz = 32'd4096;        tl = 8'd16;  end
        1: begin sz = 32'hFFFF_FFFF;   tl = 8'd255; end
        2: begin sz = 32'd0;           tl = 8'd1;   end
        3: begin sz = 32'd3;           tl = 8'd200; end
        4: begin sz = 32'd20;          tl = 8'd0;   end
        5: begin sz = $urandom_range(4, 120); tl = 8'($urandom_range(1, 255)); end
        default: begin sz = 32'h8000_0000; tl = 8'd128; end
      endcase
      write_reg(REG_SECTION_SIZE, sz);
      write_reg(REG_TAG_LIMIT, {24'($urandom), tl});
      setting_cnt++;
      calm = (p == 1 || p == 2);
      mark = pushed_cnt;
      while (pushed_cnt - mark < 15) add_section();
      drain();
    end

    $display("Sent %0d section bytes in %0d sections under %0d register settings.",
             sent_cnt, section_cnt, setting_cnt);
    $display("Checked %0d result words, %0d failures.", checked_cnt, bad_cnt);
    if (bad_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

FILE: signature_section_parser.f
rtl/core/ssp_pkg.sv
rtl/core/ssp_parse.sv
rtl/core/ssp_outq.sv
rtl/core/signature_section_parser.sv
tb/tb_top.sv
